/* rtl/core/awb_gain_register_writer_unit_assert.svh */
// Assertion macros for the white-balance gain writer's record emitter.
`ifndef AWB_GAIN_REGISTER_WRITER_UNIT_ASSERT_SVH
`define AWB_GAIN_REGISTER_WRITER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define AGRW_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("agrw assertion failed");
`define AGRW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("agrw assertion failed");
`else
`define AGRW_ASSERT_IMPLIES(name, ante, cons)
`define AGRW_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* rtl/core/agrw_pkg.sv */
// Types and constants of the white-balance gain register writer.
package agrw_pkg;

  localparam int DVD_W       = 28;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_CYCLES  = DVD_W / DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  localparam logic [15:0]      RATIO_ONE    = 16'd512;
  localparam logic [15:0]      GAIN_UNITY   = 16'h0100;
  localparam logic [15:0]      GOLDEN_RESET = 16'd512;
  localparam logic [DVD_W-1:0] UNITY_DVD    = 28'h0020000;

  localparam logic CFG_GOLDEN_RG = 1'b0;
  localparam logic CFG_GOLDEN_BG = 1'b1;

  localparam logic [15:0] ENABLE_ADDR    = 16'h3130;
  localparam logic [15:0] RED_HI_ADDR    = 16'h0210;
  localparam logic [15:0] RED_LO_ADDR    = 16'h0211;
  localparam logic [15:0] BLUE_HI_ADDR   = 16'h0212;
  localparam logic [15:0] BLUE_LO_ADDR   = 16'h0213;
  localparam logic [15:0] GREEN1_HI_ADDR = 16'h020E;
  localparam logic [15:0] GREEN1_LO_ADDR = 16'h020F;
  localparam logic [15:0] GREEN2_HI_ADDR = 16'h0214;
  localparam logic [15:0] GREEN2_LO_ADDR = 16'h0215;
  localparam logic [7:0]  ENABLE_DATA    = 8'h01;

  typedef struct packed {
    logic [15:0] measured_rg;
    logic [15:0] measured_bg;
  } meas_t;

  typedef struct packed {
    logic        status;
    logic [15:0] reg_addr;
    logic [7:0]  reg_data;
    logic        last;
  } wr_t;

  typedef struct packed {
    logic        err;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } gain_rec_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [15:0]      divisor;
  } div_req_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_RATIO,
    C_UNITY,
    C_CROSS,
    C_PUSH
  } calc_state_t;

  typedef enum logic [3:0] {
    STEP_ENABLE,
    STEP_RED_HI,
    STEP_RED_LO,
    STEP_BLUE_HI,
    STEP_BLUE_LO,
    STEP_GREEN1_HI,
    STEP_GREEN1_LO,
    STEP_GREEN2_HI,
    STEP_GREEN2_LO
  } step_t;

endpackage

/* rtl/core/awb_gain_register_writer_unit.sv */
// Top level of the white-balance gain register writer.
//
//  channel | direction | handshake            | payload
//  meas    | in        | meas_valid/ready     | measured_rg, measured_bg
//  wr      | out       | wr_valid/ready       | status, reg_addr, reg_data, last
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// A full calculation runs three passes of the shared 4-bit-per-cycle dividers (ratios,
// unity gains, cross gain), plus entry and queue push. A zero measured ratio is screened
// before any division; a zero correction ratio after the ratio pass.
// Each record gives nine writes at one per cycle while wr_ready is high (one error write on a zero ratio),
// overlapped with the next calculation through the record queue.
// Reset is synchronous; no clearing pass. A stalled wr side backs up the queue, then meas.
module awb_gain_register_writer_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            meas_valid,
  output logic            meas_ready,
  input  agrw_pkg::meas_t meas,
  output logic            wr_valid,
  input  logic            wr_ready,
  output agrw_pkg::wr_t   wr,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data
);
  import agrw_pkg::*;

  logic [15:0] golden_rg;
  logic [15:0] golden_bg;
  logic        q_full;
  logic        q_push;
  logic        q_empty;
  logic        q_pop;
  gain_rec_t   q_wdata;
  gain_rec_t   q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      golden_rg <= GOLDEN_RESET;
      golden_bg <= GOLDEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GOLDEN_RG: golden_rg <= cfg_data;
        CFG_GOLDEN_BG: golden_bg <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  agrw_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .meas_valid (meas_valid),
    .meas_ready (meas_ready),
    .meas       (meas),
    .golden_rg  (golden_rg),
    .golden_bg  (golden_bg),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  agrw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  agrw_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_rdata  (q_rdata),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr       (wr)
  );

endmodule

/* rtl/core/agrw_div.sv */
// Iterative restoring divider, four quotient bits per cycle, low 16 quotient bits kept.
module agrw_div (
  input  logic               clk,
  input  logic               rst,
  input  agrw_pkg::div_req_t req,
  output logic               done,
  output logic [15:0]        quotient
);
  import agrw_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [15:0]          rem;
  logic [15:0]          rem_next;
  logic [DVD_W-1:0]     dvd;
  logic [DVD_W-1:0]     dvd_next;
  logic [15:0]          quo;
  logic [15:0]          quo_next;
  logic [15:0]          dsr;

  always_comb begin
    logic [16:0] trial;
    rem_next = rem;
    dvd_next = dvd;
    quo_next = quo;
    trial    = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial    = {rem_next, dvd_next[DVD_W-1]};
      dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem_next = 16'(trial - {1'b0, dsr});
        quo_next = {quo_next[14:0], 1'b1};
      end else begin
        rem_next = trial[15:0];
        quo_next = {quo_next[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      quo <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

/* rtl/core/agrw_calc.sv */
// Front end: takes measurements, screens zero ratios and works out the three gains.
module agrw_calc (
  input  logic                clk,
  input  logic                rst,
  input  logic                meas_valid,
  output logic                meas_ready,
  input  agrw_pkg::meas_t     meas,
  input  logic [15:0]         golden_rg,
  input  logic [15:0]         golden_bg,
  input  logic                q_full,
  output logic                q_push,
  output agrw_pkg::gain_rec_t q_wdata
);
  import agrw_pkg::*;

  calc_state_t state;
  calc_state_t state_next;
  logic        hold_valid;
  meas_t       hold;
  logic        hold_pop;
  div_req_t    req_a;
  div_req_t    req_b;
  logic        done_a;
  logic        done_b;
  logic [15:0] q_a;
  logic [15:0] q_b;
  logic [15:0] ratio_r;
  logic [15:0] ratio_b;
  logic [15:0] gain_red;
  logic [15:0] gain_green;
  logic [15:0] gain_blue;
  logic        err;
  logic        use_r;
  logic        meas_zero;
  logic        ratio_zero;
  logic        both_high;
  logic        pick_r;

  agrw_div u_div_a (.clk(clk), .rst(rst), .req(req_a), .done(done_a), .quotient(q_a));
  agrw_div u_div_b (.clk(clk), .rst(rst), .req(req_b), .done(done_b), .quotient(q_b));

  assign meas_ready = !hold_valid;
  assign meas_zero  = (hold.measured_rg == '0) || (hold.measured_bg == '0);
  assign ratio_zero = (q_a == '0) || (q_b == '0);
  assign both_high  = (q_a >= RATIO_ONE) && (q_b >= RATIO_ONE);
  assign pick_r     = (ratio_r < RATIO_ONE) && ((ratio_b >= RATIO_ONE) || (q_a >= q_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (meas_valid && meas_ready) begin
      hold_valid <= 1'b1;
    end else if (hold_pop) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (meas_valid && meas_ready) begin
      hold <= meas;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      C_IDLE: begin
        if (hold_valid) begin
          state_next = meas_zero ? C_PUSH : C_RATIO;
        end
      end
      C_RATIO: begin
        if (done_a && done_b) begin
          state_next = (ratio_zero || both_high) ? C_PUSH : C_UNITY;
        end
      end
      C_UNITY: begin
        if (done_a) begin
          state_next = C_CROSS;
        end
      end
      C_CROSS: begin
        if (done_a) begin
          state_next = C_PUSH;
        end
      end
      C_PUSH: begin
        if (!q_full) begin
          state_next = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_comb begin
    hold_pop = 1'b0;
    q_push   = 1'b0;
    req_a    = '0;
    req_b    = '0;
    unique case (state)
      C_IDLE: begin
        hold_pop       = hold_valid;
        req_a.start    = hold_valid && !meas_zero;
        req_a.dividend = {3'b000, golden_rg, 9'b0};
        req_a.divisor  = hold.measured_rg;
        req_b.start    = hold_valid && !meas_zero;
        req_b.dividend = {3'b000, golden_bg, 9'b0};
        req_b.divisor  = hold.measured_bg;
      end
      C_RATIO: begin
        req_a.start    = done_a && done_b && !ratio_zero && !both_high;
        req_a.dividend = UNITY_DVD;
        req_a.divisor  = q_a;
        req_b.start    = done_a && done_b && !ratio_zero && !both_high;
        req_b.dividend = UNITY_DVD;
        req_b.divisor  = q_b;
      end
      C_UNITY: begin
        req_a.start    = done_a;
        req_a.dividend = pick_r ? {4'b0000, ratio_b, 8'b0} : {4'b0000, ratio_r, 8'b0};
        req_a.divisor  = pick_r ? ratio_r : ratio_b;
      end
      C_CROSS: begin
      end
      C_PUSH: begin
        q_push = !q_full;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (hold_valid) begin
          err <= meas_zero;
        end
      end
      C_RATIO: begin
        if (done_a && done_b) begin
          ratio_r    <= q_a;
          ratio_b    <= q_b;
          err        <= ratio_zero;
          gain_red   <= {1'b0, q_a[15:1]};
          gain_green <= GAIN_UNITY;
          gain_blue  <= {1'b0, q_b[15:1]};
        end
      end
      C_UNITY: begin
        if (done_a) begin
          use_r <= pick_r;
          if (pick_r) begin
            gain_red   <= GAIN_UNITY;
            gain_green <= q_a;
          end else begin
            gain_blue  <= GAIN_UNITY;
            gain_green <= q_b;
          end
        end
      end
      C_CROSS: begin
        if (done_a) begin
          if (use_r) begin
            gain_blue <= q_a;
          end else begin
            gain_red <= q_a;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign q_wdata = '{err: err, red: gain_red, green: gain_green, blue: gain_blue};

endmodule

/* rtl/core/agrw_queue.sv */
// Small queue of gain records between the calculator and the write sequencer.
module agrw_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  agrw_pkg::gain_rec_t wdata,
  output logic                full,
  input  logic                pop,
  output agrw_pkg::gain_rec_t rdata,
  output logic                empty
);
  import agrw_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  gain_rec_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

/* rtl/core/agrw_emit.sv */
// Back end: turns each gain record into its run of sensor register writes.
`include "awb_gain_register_writer_unit_assert.svh"
module agrw_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  output logic                q_pop,
  input  agrw_pkg::gain_rec_t q_rdata,
  output logic                wr_valid,
  input  logic                wr_ready,
  output agrw_pkg::wr_t       wr
);
  import agrw_pkg::*;

  logic      active;
  step_t     step;
  gain_rec_t rec;
  wr_t       item_next;
  logic      is_last;
  logic      advance;

  assign is_last = rec.err || (step == STEP_GREEN2_LO);
  assign advance = active && (!wr_valid || wr_ready);
  assign q_pop   = !q_empty && (!active || (advance && is_last));

  always_comb begin
    item_next = '0;
    if (rec.err) begin
      item_next.status = 1'b1;
      item_next.last   = 1'b1;
    end else begin
      unique case (step)
        STEP_ENABLE: begin
          item_next.reg_addr = ENABLE_ADDR;
          item_next.reg_data = ENABLE_DATA;
        end
        STEP_RED_HI: begin
          item_next.reg_addr = RED_HI_ADDR;
          item_next.reg_data = rec.red[15:8];
        end
        STEP_RED_LO: begin
          item_next.reg_addr = RED_LO_ADDR;
          item_next.reg_data = rec.red[7:0];
        end
        STEP_BLUE_HI: begin
          item_next.reg_addr = BLUE_HI_ADDR;
          item_next.reg_data = rec.blue[15:8];
        end
        STEP_BLUE_LO: begin
          item_next.reg_addr = BLUE_LO_ADDR;
          item_next.reg_data = rec.blue[7:0];
        end
        STEP_GREEN1_HI: begin
          item_next.reg_addr = GREEN1_HI_ADDR;
          item_next.reg_data = rec.green[15:8];
        end
        STEP_GREEN1_LO: begin
          item_next.reg_addr = GREEN1_LO_ADDR;
          item_next.reg_data = rec.green[7:0];
        end
        STEP_GREEN2_HI: begin
          item_next.reg_addr = GREEN2_HI_ADDR;
          item_next.reg_data = rec.green[15:8];
        end
        STEP_GREEN2_LO: begin
          item_next.reg_addr = GREEN2_LO_ADDR;
          item_next.reg_data = rec.green[7:0];
          item_next.last     = 1'b1;
        end
        default: item_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      step     <= STEP_ENABLE;
      wr_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
        step   <= STEP_ENABLE;
      end else if (advance && is_last) begin
        active <= 1'b0;
      end else if (advance) begin
        step <= step_t'(step + 4'd1);
      end
      if (advance) begin
        wr_valid <= 1'b1;
      end else if (wr_ready) begin
        wr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec <= q_rdata;
    end
    if (advance) begin
      wr <= item_next;
    end
  end

  `AGRW_ASSERT_IMPLIES(a_error_is_last, wr_valid && wr.status, wr.last)
  `AGRW_ASSERT_IMPLIES(a_last_at_green2, wr_valid && wr.last && !wr.status, wr.reg_addr == GREEN2_LO_ADDR)
  `AGRW_ASSERT_NEXT(a_run_continues, wr_valid && wr_ready && !wr.last, active || wr_valid)

endmodule
